// ===== rtl/asoa_pkg.sv =====
// Shared constants and types for the ADC scan oversample accumulator.
`timescale 1ns / 1ps
`default_nettype none

package asoa_pkg;

   // Channel count and derived widths
   localparam int CHANNELS     = 8;
   localparam int CH_W         = $clog2(CHANNELS);
   localparam int SAMPLE_W     = 10;
   localparam int SUM_W        = 16;
   localparam int CFG_W        = 7;
   localparam int PASS_W       = 6;
   localparam int MAX_PASSES   = 64;
   localparam int PASSES_RESET = 15;

   // Result kinds
   localparam logic KIND_MUX = 1'b0;
   localparam logic KIND_SUM = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADD  = 4'b0010,
      ST_UPD  = 4'b0100,
      ST_SUM  = 4'b1000
   } asoa_state_type;

   // Control from the sequencer to the accumulator bank
   typedef struct packed {
      logic            add_en;
      logic            clr_en;
      logic [CH_W-1:0] idx;
   } asoa_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/adc_scan_oversample_accumulator.sv =====
// Flow: an input transfer in the idle state is followed by the add state, then the update state offers
//   the mux-update result. A frame end then issues the 8 channel sums, one channel per cycle while the
//   output is ready, set by the sequencer walking the single accumulator read port.
// The block is ready only in the idle state, so it takes no new sample while one is being added or its
//   results are being issued; output stalls prolong this.
// Reset (synchronous, active high) clears all sums, the pass count, sets scan position 1
//   and the pass register to 15.
`timescale 1ns / 1ps
`default_nettype none

module adc_scan_oversample_accumulator
   import asoa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [CFG_W-1:0]    csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_kind,
   output logic      [CH_W-1:0]     rsp_channel,
   output logic      [CH_W-1:0]     rsp_next_mux,
   output logic      [SUM_W-1:0]    rsp_channel_sum,
   output logic                     rsp_last
);

   asoa_ctrl_type       ctrl;
   logic [SAMPLE_W-1:0] sample;
   logic [SUM_W-1:0]    rd_data;

   // Sequencer
   asoa_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_channel     (rsp_channel),
      .rsp_next_mux    (rsp_next_mux),
      .rsp_channel_sum (rsp_channel_sum),
      .rsp_last        (rsp_last),
      .ctrl            (ctrl),
      .sample          (sample),
      .rd_data         (rd_data)
   );

   // Accumulator bank
   asoa_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .sample  (sample),
      .rd_data (rd_data)
   );

   // Never take an item while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   // The cycle after an input transfer is the add cycle
   a_add_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!rsp_valid && !req_ready))
      else $error("add cycle skipped");

   // Mux-update results carry no sum
   a_mux_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_MUX) |-> (rsp_channel_sum == '0))
      else $error("mux update carries a sum");

   // The last sum of a frame belongs to the last channel
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_SUM && rsp_last) |->
         (rsp_channel == CH_W'(CHANNELS - 1)))
      else $error("frame closed on wrong channel");

endmodule

`default_nettype wire

// ===== rtl/asoa_accum.sv =====
// Per-channel accumulator bank with one shared adder and a single read port.
`timescale 1ns / 1ps
`default_nettype none

module asoa_accum
   import asoa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire asoa_ctrl_type       ctrl,
   input  wire logic [SAMPLE_W-1:0] sample,
   output logic      [SUM_W-1:0]    rd_data
);

   logic [SUM_W-1:0] acc_ff [CHANNELS];
   logic [SUM_W-1:0] sum_in;

   // Read the selected channel
   assign rd_data = acc_ff[ctrl.idx];

   // Shared adder, wraps modulo 2^16
   assign sum_in = rd_data + SUM_W'(sample);

   // Accumulate, clear after a sum transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (ctrl.clr_en) begin
         acc_ff[ctrl.idx] <= '0;
      end else if (ctrl.add_en) begin
         acc_ff[ctrl.idx] <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/asoa_seq.sv =====
// Sequencer: scan position, pass counting, result issue and the pass register.
`timescale 1ns / 1ps
`default_nettype none

module asoa_seq
   import asoa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [CFG_W-1:0]    csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_kind,
   output logic      [CH_W-1:0]     rsp_channel,
   output logic      [CH_W-1:0]     rsp_next_mux,
   output logic      [SUM_W-1:0]    rsp_channel_sum,
   output logic                     rsp_last,
   output asoa_ctrl_type            ctrl,
   output logic      [SAMPLE_W-1:0] sample,
   input  wire logic [SUM_W-1:0]    rd_data
);

   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

   asoa_state_type      state_ff, state_in;
   logic [CFG_W-1:0]    passes_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [CH_W-1:0]     pos_ff, pos_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic [CH_W-1:0]     cred_ff, cred_in;
   logic [CH_W-1:0]     mux_ff, mux_in;
   logic                emit_ff, emit_in;
   logic [CH_W-1:0]     idx_ff, idx_in;

   logic [CH_W-1:0]     cred;
   logic [CH_W:0]       pos_inc;
   logic [CH_W-1:0]     next_pos;
   logic [CFG_W-1:0]    limit;
   logic [CFG_W-1:0]    cnt;
   logic                req_xfer;

   assign req_xfer = req_valid && req_ready;
   assign sample   = sample_ff;

   // Credit the channel one behind the scan position
   assign cred     = (pos_ff == '0) ? LAST_CH : pos_ff - CH_W'(1);
   assign pos_inc  = {1'b0, pos_ff} + (CH_W+1)'(1);
   assign next_pos = (pos_inc >= (CH_W+1)'(CHANNELS)) ? '0 : pos_inc[CH_W-1:0];

   // Clamp the pass limit to 1..64
   always_comb begin
      if (passes_ff == '0) begin
         limit = CFG_W'(1);
      end else if (passes_ff > CFG_W'(MAX_PASSES)) begin
         limit = CFG_W'(MAX_PASSES);
      end else begin
         limit = passes_ff;
      end
   end
   assign cnt = {1'b0, pass_ff} + CFG_W'(1);

   // Next-state and datapath control
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      pass_in       = pass_ff;
      cred_in       = cred_ff;
      mux_in        = mux_ff;
      emit_in       = emit_ff;
      idx_in        = idx_ff;
      ctrl.add_en   = 1'b0;
      ctrl.clr_en   = 1'b0;
      ctrl.idx      = idx_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      rsp_kind      = KIND_MUX;
      rsp_channel   = cred_ff;
      rsp_next_mux  = mux_ff;
      rsp_channel_sum = '0;
      rsp_last      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ctrl.add_en = 1'b1;
            ctrl.idx    = cred;
            cred_in     = cred;
            mux_in      = next_pos;
            pos_in      = next_pos;
            emit_in     = 1'b0;
            if (pos_ff == '0) begin
               if (cnt >= limit) begin
                  pass_in = '0;
                  emit_in = 1'b1;
               end else begin
                  pass_in = cnt[PASS_W-1:0];
               end
            end
            state_in = ST_UPD;
         end
         ST_UPD: begin
            rsp_valid = 1'b1;
            rsp_last  = !emit_ff;
            if (rsp_ready) begin
               idx_in   = '0;
               state_in = emit_ff ? ST_SUM : ST_IDLE;
            end
         end
         ST_SUM: begin
            rsp_valid       = 1'b1;
            rsp_kind        = KIND_SUM;
            rsp_channel     = idx_ff;
            rsp_channel_sum = rd_data;
            rsp_last        = (idx_ff == LAST_CH);
            if (rsp_ready) begin
               ctrl.clr_en = 1'b1;
               if (idx_ff == LAST_CH) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + CH_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= CH_W'(1);
         pass_ff   <= '0;
         passes_ff <= CFG_W'(PASSES_RESET);
         emit_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         pass_ff  <= pass_in;
         emit_ff  <= emit_in;
         idx_ff   <= idx_in;
         if (csr_wr_en) begin
            passes_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_ff <= req_sample;
      end
      cred_ff <= cred_in;
      mux_ff  <= mux_in;
   end

endmodule

`default_nettype wire

// ===== verif/tb_adc_scan_oversample_accumulator.sv =====
// Self-checking testbench for the ADC scan oversample accumulator.
`timescale 1ns / 1ps

module tb_adc_scan_oversample_accumulator
   import asoa_pkg::*;
();

   // Cycles without any transfer before the run is declared hung
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTS  = 100;

   typedef struct {
      logic             kind;
      logic [CH_W-1:0]  channel;
      logic [CH_W-1:0]  next_mux;
      logic [SUM_W-1:0] channel_sum;
      logic             last;
   } scan_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_kind;
   logic [CH_W-1:0]     rsp_channel;
   logic [CH_W-1:0]     rsp_next_mux;
   logic [SUM_W-1:0]    rsp_channel_sum;
   logic                rsp_last;

   // Scan model state
   logic [CH_W-1:0]     scan_pos;
   logic [PASS_W-1:0]   pass_cnt;
   logic [CFG_W-1:0]    pass_cfg;
   logic [SUM_W-1:0]    chan_acc [CHANNELS];

   scan_result_type     expected_scan_results [$];
   logic [SAMPLE_W-1:0] sample_fifo [$];

   int  send_idle_pct = 0;
   int  rcv_idle_pct  = 0;
   int  hold_left     = 0;
   bit  req_taken     = 1'b0;
   int  idle_cycles   = 0;
   int  err_count     = 0;
   int  items_queued  = 0;
   int  items_accepted = 0;
   int  sums_checked  = 0;
   int  frames_seen   = 0;

   adc_scan_oversample_accumulator u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_channel     (rsp_channel),
      .rsp_next_mux    (rsp_next_mux),
      .rsp_channel_sum (rsp_channel_sum),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      if (err_count < MAX_PRINTS) begin
         $display("ERROR %0t: %s", $realtime, msg);
      end
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   // Credit one sample to its channel and queue the results it causes
   task automatic credit_sample(input logic [SAMPLE_W-1:0] s);
      logic [CH_W-1:0] cred;
      logic [CH_W-1:0] nxt;
      int              lim;
      int              cnt;
      bit              emit;
      scan_result_type r;
      cred = (scan_pos == 0) ? CH_W'(CHANNELS - 1) : CH_W'(scan_pos - 1);
      chan_acc[cred] = chan_acc[cred] + SUM_W'(s);
      lim = int'(pass_cfg);
      if (lim == 0) lim = 1;
      if (lim > MAX_PASSES) lim = MAX_PASSES;
      emit = 1'b0;
      // Close a pass when the last channel is credited
      if (scan_pos == 0) begin
         cnt = int'(pass_cnt) + 1;
         if (cnt >= lim) begin
            pass_cnt = '0;
            emit = 1'b1;
         end else begin
            pass_cnt = PASS_W'(cnt);
         end
      end
      nxt = (int'(scan_pos) + 1 >= CHANNELS) ? '0 : CH_W'(scan_pos + 1);
      scan_pos = nxt;
      r.kind = KIND_MUX;
      r.channel = cred;
      r.next_mux = nxt;
      r.channel_sum = '0;
      r.last = !emit;
      expected_scan_results.push_back(r);
      // Emit all sums in channel order, then clear
      if (emit) begin
         for (int i = 0; i < CHANNELS; i++) begin
            r.kind = KIND_SUM;
            r.channel = CH_W'(i);
            r.channel_sum = chan_acc[i];
            r.last = (i == CHANNELS - 1);
            expected_scan_results.push_back(r);
            chan_acc[i] = '0;
         end
      end
   endtask

   task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
      sample_fifo.push_back(s);
      items_queued++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return SAMPLE_W'($urandom_range(1023));
      endcase
   endfunction

   // Wait until every queued sample is accepted and every result returned
   task automatic wait_idle();
      while (sample_fifo.size() != 0 || items_accepted != items_queued ||
             expected_scan_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_passes(input logic [CFG_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pass_cfg = v;
      @(negedge clock);
   endtask

   // Driver: offer the next sample, hold it until the transfer
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (sample_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_sample <= sample_fifo.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random backpressure, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Monitor: predict on input transfers, check output transfers, watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            credit_sample(req_sample);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_scan_results.size() == 0) begin
               report_error($sformatf("unexpected result kind %0d channel %0d",
                                      rsp_kind, rsp_channel));
            end else begin
               scan_result_type want;
               want = expected_scan_results.pop_front();
               check_field("kind", 32'(rsp_kind), 32'(want.kind));
               check_field("channel", 32'(rsp_channel), 32'(want.channel));
               check_field("next_mux", 32'(rsp_next_mux), 32'(want.next_mux));
               check_field("channel_sum", 32'(rsp_channel_sum),
                           32'(want.channel_sum));
               check_field("last", 32'(rsp_last), 32'(want.last));
               if (want.kind == KIND_SUM) sums_checked++;
               if (want.kind == KIND_SUM && want.last) frames_seen++;
            end
         end
         if (req_taken || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("adc_scan_oversample_accumulator regression: fail");
            $finish;
         end
      end
   end

   initial begin
      // Model reset state
      scan_pos = 3'd1;
      pass_cnt = '0;
      pass_cfg = CFG_W'(PASSES_RESET);
      for (int i = 0; i < CHANNELS; i++) chan_acc[i] = '0;
      send_idle_pct = 24;
      rcv_idle_pct = 73;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: one scan at the reset pass count, no sums expected
      queue_sample(10'd0);   queue_sample(10'd1023); queue_sample(10'h155);
      queue_sample(10'h2AA); queue_sample(10'd1);    queue_sample(10'd512);
      queue_sample(10'd1022); queue_sample(10'd0);
      wait_idle();
      // Pass count already at the new limit: next scan end emits
      write_passes(CFG_W'(1));
      for (int i = 0; i < CHANNELS; i++) queue_sample(10'd1023);
      wait_idle();
      // Zero passes act as one
      write_passes(CFG_W'(0));
      queue_sample(10'h155); queue_sample(10'h2AA); queue_sample(10'd0);
      queue_sample(10'd1023); queue_sample(10'h2AA); queue_sample(10'h155);
      queue_sample(10'd1);   queue_sample(10'd1023);
      wait_idle();

      // Sender mostly busy, receiver mostly stalled, with a long hold-off
      write_passes(CFG_W'(2));
      for (int i = 0; i < 80; i++) queue_sample(pick_sample());
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      wait_idle();

      // Sender mostly idle, receiver mostly ready
      send_idle_pct = 73;
      rcv_idle_pct = 24;
      write_passes(CFG_W'(3));
      for (int i = 0; i < 80; i++) queue_sample(pick_sample());
      wait_idle();
      // Out-of-range pass count saturates: no frame closes within these scans
      write_passes('1);
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(7) == 0) queue_sample(pick_sample());
         else queue_sample(SAMPLE_W'($urandom_range(1023, 960)));
      end
      wait_idle();

      // No idling on either side
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      write_passes(CFG_W'(MAX_PASSES));
      for (int i = 0; i < 40; i++) queue_sample(pick_sample());
      wait_idle();
      // Drop below the running pass count
      write_passes(CFG_W'(4));
      for (int i = 0; i < 48; i++) queue_sample(pick_sample());
      wait_idle();
      repeat (8) @(negedge clock);

      if (expected_scan_results.size() != 0) begin
         report_error($sformatf("%0d expected results never arrived",
                                expected_scan_results.size()));
      end
      $display("covered %0d samples over pass limits 15, 1, 0, 2, 3, 127, 64 and 4",
               items_accepted);
      $display("checked %0d channel sums in %0d frames, %0d errors",
               sums_checked, frames_seen, err_count);
      if (err_count == 0) begin
         $display("adc_scan_oversample_accumulator regression: pass");
      end else begin
         $display("adc_scan_oversample_accumulator regression: fail");
      end
      $finish;
   end

endmodule
